@@ hw/rtl/lru_key_value_cache_assert.svh @@
// assertion macros used by the lru key-value cache datapath
// expects signals named clock and reset in the including module
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// condition holds at every edge out of reset
`define LKVC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LKVC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lkvc_pkg.sv @@
// types and constants for the lru key-value cache
// no dependencies; imported by every rtl module of the block
package lkvc_pkg;

   localparam int DATA_W     = 32;
   localparam int CAP_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0]        REG_CAPACITY   = 1'b0;
   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic apply;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_put;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ hw/rtl/lru_key_value_cache.sv @@
// lru key-value cache: a get passes capture, search, apply (registered read of the
// value memory) and deliver before rsp_valid rises; a put lands in the store when
// apply ends and sends nothing. req_ready is high only in idle, so a new request is
// taken only after the last one is through, later while a finished word waits.
// synchronous reset clears valid bits, ranks, entry count, output valid and sets
// capacity to 16; key and value stores are not cleared
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CAP_W-1:0] capacity_ff;
   logic             sel_capacity;
   ctrl_cmd_type     cmd;
   dp_status_type    status;

   assign sel_capacity = paddr[CSR_ADDR_W-1:2] == REG_CAPACITY;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (psel && penable && pwrite && sel_capacity) begin
         capacity_ff <= pwdata[CAP_W-1:0];
      end
   end

   assign prdata = sel_capacity ? CSR_DATA_W'(capacity_ff) : '0;
   assign pready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkvc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .capacity  (capacity_ff),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/lkvc_ctrl.sv @@
// sequencer for the lru key-value cache: capture, search, apply, deliver
// depends on lkvc_pkg; drives lkvc_datapath through ctrl_cmd_type
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            // a put has no word to send
            state_in  = status.is_put ? ST_IDLE : ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/lkvc_datapath.sv @@
// entry store, recency ranks, value memory and output register of the cache
// depends on lkvc_pkg and lru_key_value_cache_assert.svh; driven by lkvc_ctrl
`include "lru_key_value_cache_assert.svh"

module lkvc_datapath import lkvc_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   output dp_status_type    status,
   input  logic [CAP_W-1:0] capacity,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   function automatic logic [MAX_ENTRIES-1:0] lowest_one(input logic [MAX_ENTRIES-1:0] x);
      return x & (~x + MAX_ENTRIES'(1));
   endfunction

   req_type                 req_ff;
   logic [MAX_ENTRIES-1:0]  valid_ff, valid_in;
   logic [DATA_W-1:0]       key_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]       rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]       rank_in [MAX_ENTRIES];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [DATA_W-1:0]       value_mem [MAX_ENTRIES];
   logic [DATA_W-1:0]       rdata_ff;

   logic                    hit_ff, insert_ff;
   logic [MAX_ENTRIES-1:0]  target_oh_ff;
   logic [RANK_W-1:0]       target_rank_ff;
   logic [IDX_W-1:0]        target_idx_ff;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   // search results
   logic [MAX_ENTRIES-1:0]  match, lru_cand, target_oh;
   logic [RANK_W-1:0]       last_rank, target_rank;
   logic [IDX_W-1:0]        target_idx;
   logic [CMP_W-1:0]        cap_ext, eff_cap;
   logic                    hit, has_room, is_put, change;

   assign is_put = req_ff.op == OP_PUT;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // ranks of valid entries always form 0..count-1, so the oldest has rank count-1
   always_comb begin
      last_rank = RANK_W'(count_ff - CNT_W'(1));
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]    = valid_ff[i] && (key_ff[i] == req_ff.key);
         lru_cand[i] = valid_ff[i] && (rank_ff[i] == last_rank);
      end
      hit      = |match;
      has_room = CMP_W'(count_ff) < eff_cap;
      if (hit) begin
         target_oh = lowest_one(match);
      end else if (has_room) begin
         target_oh = lowest_one(~valid_ff);
      end else begin
         target_oh = lowest_one(lru_cand);
      end
      target_rank = '0;
      target_idx  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (target_oh[i]) begin
            target_rank = target_rank | rank_ff[i];
            target_idx  = target_idx | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         hit_ff         <= hit;
         insert_ff      <= !hit && has_room;
         target_oh_ff   <= target_oh;
         target_rank_ff <= target_rank;
         target_idx_ff  <= target_idx;
      end
   end

   // get hit touches the entry; every put touches or inserts
   assign change = cmd.apply && (is_put || hit_ff);

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (change) begin
            if (target_oh_ff[i]) begin
               rank_in[i] = '0;
               if (is_put) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (insert_ff || rank_ff[i] < target_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      count_in = count_ff + CNT_W'(change && insert_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (change && is_put && target_oh_ff[i]) begin
            key_ff[i] <= req_ff.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (change && is_put && (|target_oh_ff)) begin
         value_mem[target_idx_ff] <= req_ff.value;
      end
      if (cmd.apply && (req_ff.op == OP_GET) && hit_ff) begin
         rdata_ff <= value_mem[target_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.hit        <= hit_ff;
         rsp_data_ff.read_value <= hit_ff ? rdata_ff : MISS_VALUE;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.is_put   = is_put;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   `LKVC_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_ENTRIES), "entry count above depth")
   `LKVC_ASSERT_ALWAYS(a_count_valid, $countones(valid_ff) == count_ff,
      "count differs from valid bits")
   `LKVC_ASSERT_NEXT(a_insert_grows, change && insert_ff,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow count")
   `LKVC_ASSERT_IMPLIES(a_miss_word, rsp_valid_ff && !rsp_data_ff.hit,
      rsp_data_ff.read_value == MISS_VALUE, "miss word without miss value")

endmodule
